// File: hw/rtl/lzd_pkg.sv
// lzd_pkg: shared types and constants of the lz77 token decompressor
// no dependencies

package lzd_pkg;

  localparam int OUT_LANES = 4;

  localparam logic [1:0]  REG_EXPECTED_ADDR = 2'd0;
  localparam logic [31:0] EXPECTED_RESET    = 32'hFFFF_FFFF;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic        new_stream;
    logic [15:0] back_dist;
    logic [7:0]  copy_len;
    byte_t       literal;
    logic        lit_en;
    logic        skipped;
  } cmd_t;

endpackage

// File: hw/rtl/lzd_tok_if.sv
// lzd_tok_if: token channel of the lz77 token decompressor
// no dependencies

interface lzd_tok_if;
  logic        valid;
  logic        ready;
  logic        new_stream;
  logic [15:0] back_distance;
  logic [7:0]  match_length;
  logic [7:0]  literal_byte;

  modport source (output valid, new_stream, back_distance, match_length, literal_byte,
                  input ready);
  modport sink (input valid, new_stream, back_distance, match_length, literal_byte,
                output ready);
endinterface

// File: hw/rtl/lzd_res_if.sv
// lzd_res_if: result channel of the lz77 token decompressor, four bytes a word
// no dependencies

interface lzd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;
  logic [2:0] valid_bytes;
  logic       token_done;
  logic       copy_skipped;

  modport source (output valid, out_byte0, out_byte1, out_byte2, out_byte3, valid_bytes,
                  token_done, copy_skipped, input ready);
  modport sink (input valid, out_byte0, out_byte1, out_byte2, out_byte3, valid_bytes,
                token_done, copy_skipped, output ready);
endinterface

// File: hw/rtl/lzd_front.sv
// lzd_front: accepts tokens, tracks the produced byte count and classifies each token
// depends on lzd_pkg and lzd_tok_if

module lzd_front #(
  parameter int unsigned WINDOW_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  lzd_tok_if.sink       in_tok,
  input  logic [31:0]   lit_limit,
  output lzd_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  import lzd_pkg::*;

  localparam logic [16:0] WIN_LIMIT = 17'(WINDOW_BYTES);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_EVAL = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t     state_r, state_nxt;
  logic [31:0] count_r, count_nxt;
  logic        new_r, new_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic [7:0]  len_r, len_nxt;
  byte_t       lit_r, lit_nxt;
  logic [7:0]  copy_len_r, copy_len_nxt;
  logic        skip_r, skip_nxt;

  logic        match_req;
  logic        in_win;
  logic        do_copy;
  logic [32:0] sum;
  logic        lit_en;

  assign match_req = (len_r != 8'd0) && (dist_r != 16'd0);
  assign in_win    = ({1'b0, dist_r} <= WIN_LIMIT) && (32'(dist_r) <= count_r);
  assign do_copy   = match_req && in_win;
  assign sum       = {1'b0, count_r} + 33'(len_r);
  assign lit_en    = count_r < lit_limit;

  assign in_tok.ready = (state_r == F_IDLE);

  assign cmd_valid = (state_r == F_PUSH);
  assign cmd = '{new_stream: new_r, back_dist: dist_r, copy_len: copy_len_r, literal: lit_r,
                 lit_en: lit_en, skipped: skip_r};

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    new_nxt      = new_r;
    dist_nxt     = dist_r;
    len_nxt      = len_r;
    lit_nxt      = lit_r;
    copy_len_nxt = copy_len_r;
    skip_nxt     = skip_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_tok.valid) begin
          new_nxt   = in_tok.new_stream;
          dist_nxt  = in_tok.back_distance;
          len_nxt   = in_tok.match_length;
          lit_nxt   = in_tok.literal_byte;
          if (in_tok.new_stream) begin
            count_nxt = 32'd0;
          end
          state_nxt = F_EVAL;
        end
      end
      F_EVAL: begin
        skip_nxt     = match_req && !in_win;
        copy_len_nxt = do_copy ? len_r : 8'd0;
        if (do_copy) begin
          count_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (cmd_ready) begin
          count_nxt = count_r + 32'(lit_en);
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      count_r <= 32'd0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    new_r      <= new_nxt;
    dist_r     <= dist_nxt;
    len_r      <= len_nxt;
    lit_r      <= lit_nxt;
    copy_len_r <= copy_len_nxt;
    skip_r     <= skip_nxt;
  end

endmodule

// File: hw/rtl/lzd_cmd_fifo.sv
// lzd_cmd_fifo: two-entry command queue between front and back
// depends on lzd_pkg

module lzd_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  lzd_pkg::cmd_t push_data,
  output logic          push_ready,
  output logic          pop_valid,
  output lzd_pkg::cmd_t pop_data,
  input  logic          pop_ready
);
  import lzd_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = entry_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
    if (do_push) begin
      entry_r[wr_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/lzd_back.sv
// lzd_back: runs commands against the history memory and packs output bytes into words
// depends on lzd_pkg and lzd_res_if

module lzd_back #(
  parameter int unsigned WINDOW_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lzd_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  lzd_res_if.source     out_res
);
  import lzd_pkg::*;

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] WIN       = PW'(WINDOW_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_BYTES - 1);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_COPY = 3'b010,
    B_LIT  = 3'b100
  } bstate_t;

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    addr_inc = (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  byte_t   mem [WINDOW_BYTES];
  bstate_t state_r, state_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] ra_r, ra_nxt;
  logic [7:0]    remain_r, remain_nxt;
  byte_t         lit_r, lit_nxt;
  logic          lit_en_r, lit_en_nxt;
  logic          skip_r, skip_nxt;
  byte_t         pk_r [OUT_LANES];
  logic [1:0]    pk_cnt_r;
  byte_t         rd_q_r, fwd_d_r;
  logic          fwd_r;

  logic          out_valid_r;
  byte_t         out_b_r [OUT_LANES];
  logic [2:0]    out_cnt_r;
  logic          out_done_r, out_skip_r;

  logic [AW-1:0] wp_base;
  logic [PW-1:0] dist_w, back_sum, start_w;
  logic          can_emit, active, push, last, emit_req, go, we;
  byte_t         byte_in;
  byte_t         pk_ins [OUT_LANES];
  logic [2:0]    cnt_ins;

  assign wp_base  = cmd.new_stream ? '0 : wp_r;
  assign dist_w   = PW'(cmd.back_dist);
  assign back_sum = {1'b0, wp_base} + WIN - dist_w;
  assign start_w  = (back_sum >= WIN) ? back_sum - WIN : back_sum;

  assign cmd_ready = (state_r == B_IDLE);
  assign can_emit  = !out_valid_r || out_res.ready;
  assign active    = (state_r == B_COPY) || (state_r == B_LIT);
  assign byte_in   = (state_r == B_LIT) ? lit_r : (fwd_r ? fwd_d_r : rd_q_r);
  assign push      = (state_r == B_COPY) || ((state_r == B_LIT) && lit_en_r);
  assign last      = (state_r == B_LIT) || ((remain_r == 8'd1) && !lit_en_r);
  assign emit_req  = last || (push && (pk_cnt_r == 2'd3));
  assign go        = active && (!emit_req || can_emit);
  assign we        = go && push;
  assign cnt_ins   = {1'b0, pk_cnt_r} + 3'(push);

  always_comb begin
    for (int i = 0; i < OUT_LANES; i++) begin
      pk_ins[i] = (push && (pk_cnt_r == 2'(i))) ? byte_in : pk_r[i];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    ra_nxt     = ra_r;
    remain_nxt = remain_r;
    lit_nxt    = lit_r;
    lit_en_nxt = lit_en_r;
    skip_nxt   = skip_r;
    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          wp_nxt     = wp_base;
          ra_nxt     = start_w[AW-1:0];
          remain_nxt = cmd.copy_len;
          lit_nxt    = cmd.literal;
          lit_en_nxt = cmd.lit_en;
          skip_nxt   = cmd.skipped;
          state_nxt  = (cmd.copy_len != 8'd0) ? B_COPY : B_LIT;
        end
      end
      B_COPY: begin
        if (go) begin
          wp_nxt     = addr_inc(wp_r);
          ra_nxt     = addr_inc(ra_r);
          remain_nxt = remain_r - 8'd1;
          if (remain_r == 8'd1) begin
            state_nxt = lit_en_r ? B_LIT : B_IDLE;
          end
        end
      end
      B_LIT: begin
        if (go) begin
          if (lit_en_r) begin
            wp_nxt = addr_inc(wp_r);
          end
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // history memory, read data registered, bypass when the byte just written is read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wp_r] <= byte_in;
    end
    rd_q_r  <= mem[ra_nxt];
    fwd_r   <= we && (wp_r == ra_nxt);
    fwd_d_r <= byte_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      wp_r        <= '0;
      pk_cnt_r    <= 2'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < OUT_LANES; i++) begin
        pk_r[i] <= 8'd0;
      end
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      if (go && emit_req) begin
        out_valid_r <= 1'b1;
        pk_cnt_r    <= 2'd0;
        for (int i = 0; i < OUT_LANES; i++) begin
          pk_r[i] <= 8'd0;
        end
      end else begin
        if (out_res.ready) begin
          out_valid_r <= 1'b0;
        end
        if (go) begin
          pk_cnt_r <= cnt_ins[1:0];
          for (int i = 0; i < OUT_LANES; i++) begin
            pk_r[i] <= pk_ins[i];
          end
        end
      end
    end
    ra_r     <= ra_nxt;
    remain_r <= remain_nxt;
    lit_r    <= lit_nxt;
    lit_en_r <= lit_en_nxt;
    skip_r   <= skip_nxt;
    if (go && emit_req) begin
      for (int i = 0; i < OUT_LANES; i++) begin
        out_b_r[i] <= pk_ins[i];
      end
      out_cnt_r  <= cnt_ins;
      out_done_r <= last;
      out_skip_r <= skip_r;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.out_byte0    = out_b_r[0];
  assign out_res.out_byte1    = out_b_r[1];
  assign out_res.out_byte2    = out_b_r[2];
  assign out_res.out_byte3    = out_b_r[3];
  assign out_res.valid_bytes  = out_cnt_r;
  assign out_res.token_done   = out_done_r;
  assign out_res.copy_skipped = out_skip_r;

endmodule

// File: hw/rtl/lz77_token_decompressor.sv
// lz77_token_decompressor: top level, config register, front, command queue and back
// depends on lzd_pkg, lzd_tok_if, lzd_res_if, lzd_front, lzd_cmd_fifo, lzd_back
// front steps through idle, evaluate and push per token and holds in push until queued;
// back copies byte by byte, then takes the literal step unless a copy ends without a literal
// sync active-low reset clears counts, pointer and queue; size limit returns to all ones
// history memory is not cleared and needs no clearing pass

module lz77_token_decompressor #(
  parameter int unsigned WINDOW_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  lzd_tok_if.sink     in_tok,
  lzd_res_if.source   out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lzd_pkg::*;

  logic [31:0] expected_r;
  cmd_t        f_cmd, b_cmd;
  logic        f_valid, f_ready, b_valid, b_ready;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_EXPECTED_ADDR) ? expected_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= EXPECTED_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_EXPECTED_ADDR)) begin
      expected_r <= pwdata;
    end
  end

  lzd_front #(.WINDOW_BYTES(WINDOW_BYTES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tok   (in_tok),
    .lit_limit(expected_r),
    .cmd      (f_cmd),
    .cmd_valid(f_valid),
    .cmd_ready(f_ready)
  );

  lzd_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_data (f_cmd),
    .push_ready(f_ready),
    .pop_valid (b_valid),
    .pop_data  (b_cmd),
    .pop_ready (b_ready)
  );

  lzd_back #(.WINDOW_BYTES(WINDOW_BYTES)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (b_cmd),
    .cmd_valid(b_valid),
    .cmd_ready(b_ready),
    .out_res  (out_res)
  );

endmodule

// File: sim/lz77_token_decompressor_tb.sv
`timescale 1ns / 100ps
// lz77_token_decompressor_tb: random and directed token streams, checked word by word
// against an in-bench history model; depends on lzd_pkg, lzd_tok_if, lzd_res_if
// and lz77_token_decompressor

module lz77_token_decompressor_tb;
  import lzd_pkg::*;

  localparam int unsigned WINDOW_BYTES = 4096;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned LONG_HOLD = 500;
  localparam logic [1:0]  UNUSED_ADDR = 2'd1;

  typedef struct packed {
    logic        new_stream;
    logic [15:0] back_distance;
    logic [7:0]  match_length;
    logic [7:0]  literal_byte;
  } tok_t;

  typedef struct packed {
    logic [3:0][7:0] lane;
    logic [2:0]      valid_bytes;
    logic            token_done;
    logic            copy_skipped;
  } res_word_t;

  class token_scoreboard;
    byte_t       window_mem [WINDOW_BYTES];
    bit [11:0]   wr_ptr;
    bit [31:0]   produced;
    bit [31:0]   size_limit;
    byte_t       token_bytes[$];
    res_word_t   expected_words[$];
    int unsigned errors;

    function new();
      wr_ptr = '0;
      produced = '0;
      size_limit = EXPECTED_RESET;
      errors = 0;
    endfunction

    function void append(byte_t b);
      window_mem[wr_ptr] = b;
      wr_ptr++;
      if (produced != 32'hFFFF_FFFF) produced++;
      token_bytes.insert(token_bytes.size(), b);
    endfunction

    function void note_token(tok_t t);
      bit          skip;
      bit [11:0]   rd;
      int unsigned avail;
      int          nwords, cnt;
      res_word_t   w;
      skip = 1'b0;
      token_bytes.delete();
      if (t.new_stream) begin
        produced = '0;
        wr_ptr = '0;
      end
      avail = (produced < WINDOW_BYTES) ? produced : WINDOW_BYTES;
      if (t.match_length != 0 && t.back_distance != 0) begin
        if (t.back_distance <= avail) begin
          for (int j = 0; j < t.match_length; j++) begin
            rd = wr_ptr - t.back_distance[11:0];
            append(window_mem[rd]);
          end
        end else begin
          skip = 1'b1;
        end
      end
      if (produced < size_limit) append(t.literal_byte);
      nwords = (token_bytes.size() == 0) ? 1 : (token_bytes.size() + OUT_LANES - 1) / OUT_LANES;
      for (int k = 0; k < nwords; k++) begin
        cnt = token_bytes.size() - OUT_LANES * k;
        if (cnt < 0) cnt = 0;
        if (cnt > OUT_LANES) cnt = OUT_LANES;
        for (int i = 0; i < OUT_LANES; i++)
          w.lane[i] = (i < cnt) ? token_bytes[OUT_LANES * k + i] : 8'h00;
        w.valid_bytes = cnt[2:0];
        w.token_done = (k == nwords - 1);
        w.copy_skipped = skip;
        expected_words.insert(expected_words.size(), w);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(res_word_t got);
      res_word_t want;
      if (expected_words.size() == 0) begin
        $error("word with no token pending: %h", got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      for (int i = 0; i < OUT_LANES; i++)
        compare_field($sformatf("out_byte%0d", i), want.lane[i], got.lane[i]);
      compare_field("valid_bytes", 8'(want.valid_bytes), 8'(got.valid_bytes));
      compare_field("token_done", 8'(want.token_done), 8'(got.token_done));
      compare_field("copy_skipped", 8'(want.copy_skipped), 8'(got.copy_skipped));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int unsigned cycle_count = 0;
  int unsigned hold_requests = 0;
  token_scoreboard sb;

  lzd_tok_if in_tok();
  lzd_res_if out_res();

  lz77_token_decompressor #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tok(in_tok),
    .out_res(out_res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: checks accepted words, stalls on a pattern of its own
  initial begin : drain
    int unsigned mode, mode_left, hold_left, hold_served;
    res_word_t got;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_served = 0;
    out_res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_res.valid === 1'b1 && out_res.ready) begin
        got.lane[0] = out_res.out_byte0;
        got.lane[1] = out_res.out_byte1;
        got.lane[2] = out_res.out_byte2;
        got.lane[3] = out_res.out_byte3;
        got.valid_bytes = out_res.valid_bytes;
        got.token_done = out_res.token_done;
        got.copy_skipped = out_res.copy_skipped;
        sb.check_word(got);
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_res.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_res.ready <= 1'b1;
          1: out_res.ready <= $urandom_range(0, 1);
          2: out_res.ready <= ($urandom_range(0, 3) == 0);
          default: out_res.ready <= (mode_left % 3 != 0);
        endcase
      end
    end
  end

  function automatic tok_t mk(bit ns, int unsigned d, int unsigned l, int unsigned lit);
    tok_t t;
    t.new_stream = ns;
    t.back_distance = 16'(d);
    t.match_length = 8'(l);
    t.literal_byte = 8'(lit);
    return t;
  endfunction

  function automatic int unsigned window_avail();
    return (sb.produced < WINDOW_BYTES) ? sb.produced : WINDOW_BYTES;
  endfunction

  function automatic tok_t random_token();
    tok_t t;
    int unsigned avail, pick;
    t.new_stream = ($urandom_range(0, 99) < 3);
    t.literal_byte = 8'($urandom);
    t.match_length = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 8)) : 8'($urandom);
    avail = t.new_stream ? 0 : window_avail();
    pick = $urandom_range(0, 99);
    if (pick < 10 || avail == 0)
      t.back_distance = 16'($urandom);
    else if (pick < 15)
      t.back_distance = '0;
    else if (pick < 20)
      t.back_distance = 16'(avail + $urandom_range(1, 4));
    else if (pick < 40)
      t.back_distance = 16'($urandom_range(1, (avail < 8) ? avail : 8));
    else if (pick < 55)
      t.back_distance = 16'(avail - $urandom_range(0, (avail < 4) ? avail - 1 : 3));
    else
      t.back_distance = 16'($urandom_range(1, avail));
    return t;
  endfunction

  task automatic send_token(input tok_t t);
    in_tok.valid <= 1'b1;
    in_tok.new_stream <= t.new_stream;
    in_tok.back_distance <= t.back_distance;
    in_tok.match_length <= t.match_length;
    in_tok.literal_byte <= t.literal_byte;
    @(posedge clk);
    while (!in_tok.ready) @(posedge clk);
    sb.note_token(t);
  endtask

  task automatic run_random(input int count);
    int burst, gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0 && i != 0) begin
          in_tok.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_token(random_token());
      burst--;
    end
    in_tok.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == REG_EXPECTED_ADDR) sb.size_limit = data;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_EXPECTED_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== sb.size_limit) begin
      $error("expected_output_size: expected %0h, got %0h", sb.size_limit, prdata);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_tok.valid = 1'b0;
    in_tok.new_stream = 1'b0;
    in_tok.back_distance = '0;
    in_tok.match_length = '0;
    in_tok.literal_byte = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_readback();

    // directed: extremes, overlap, skips, window edge
    send_token(mk(1, 0, 0, 8'hA5));
    send_token(mk(0, 1, 255, 8'hFF));
    send_token(mk(0, 5, 0, 8'h00));
    send_token(mk(0, 0, 7, 8'h3C));
    send_token(mk(0, 16'hFFFF, 255, 8'h81));
    send_token(mk(0, sb.produced, 3, 8'h11));
    send_token(mk(0, sb.produced + 1, 1, 8'h22));
    send_token(mk(1, 1, 3, 8'h5A));
    send_token(mk(1, 0, 0, 8'h00));
    repeat (16) send_token(mk(0, $urandom_range(1, window_avail()), 255, $urandom));
    send_token(mk(0, WINDOW_BYTES, 255, $urandom));
    send_token(mk(0, WINDOW_BYTES + 1, 1, $urandom));
    in_tok.valid <= 1'b0;
    wait_drained();

    // zero limit: copies still land, literals do not
    reg_write(REG_EXPECTED_ADDR, 32'h0);
    reg_write(UNUSED_ADDR, $urandom);
    reg_readback();
    send_token(mk(0, 1, 4, 8'h77));
    send_token(mk(0, 1, 0, 8'h66));
    send_token(mk(1, 0, 0, 8'h55));
    in_tok.valid <= 1'b0;
    wait_drained();

    reg_write(REG_EXPECTED_ADDR, 32'hFFFF_FFFF);
    hold_requests++;
    run_random(150);
    wait_drained();

    reg_write(REG_EXPECTED_ADDR, $urandom_range(1, 600));
    reg_readback();
    run_random(80);
    wait_drained();

    reg_write(REG_EXPECTED_ADDR, 32'h0);
    run_random(40);
    wait_drained();

    reg_write(REG_EXPECTED_ADDR, $urandom);
    reg_readback();
    run_random(80);
    wait_drained();

    reg_write(REG_EXPECTED_ADDR, 32'hFFFF_FFFF);
    hold_requests++;
    run_random(150);
    wait_drained();

    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
